>>> rtl/sync_framed_command_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync framed command parser
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_COMMAND_PARSER_ASSERT_SVH
`define SYNC_FRAMED_COMMAND_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// ante |-> cons in the same cycle
`define SFCP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfcp assertion failed");

// ante |=> cons in the next cycle
`define SFCP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfcp assertion failed");

`else

`define SFCP_ASSERT_IMP(label, ante, cons)
`define SFCP_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Types, codes and constants shared by the sync framed command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcp_pkg;

	localparam int unsigned PAYLOAD_STORE_DEF = 128;

	localparam int unsigned SYNC_LEN   = 4;
	localparam int unsigned SYNC_IDX_W = 2;
	localparam logic [SYNC_IDX_W-1:0] SYNC_LAST = SYNC_IDX_W'(SYNC_LEN - 1);

	localparam logic [7:0] SYNC_B0 = 8'hAA;
	localparam logic [7:0] SYNC_B1 = 8'hFF;
	localparam logic [7:0] SYNC_B2 = 8'h55;
	localparam logic [7:0] SYNC_B3 = 8'h00;

	// Command codes lie strictly between these bounds
	localparam logic [7:0] CMD_LO = 8'h80;
	localparam logic [7:0] CMD_HI = 8'h90;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_RESYNC = 1'b1;

	localparam logic [7:0] LEN_SAT = 8'hFF;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_WAIT_CMD,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [7:0]  frame_command;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        byte_kept;
		logic        frame_end;
		logic [7:0]  frame_length;
	} result_t;

	function automatic logic [7:0] sync_byte(input logic [SYNC_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = SYNC_B0;
			2'd1: b = SYNC_B1;
			2'd2: b = SYNC_B2;
			default: b = SYNC_B3;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sfcp_link_if.sv
// ----------------------------------------------------------------------------
// sfcp_link_if
// Input channel: received link bytes and resync requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcp_link_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink (input valid, input kind, input byte_value, output ready);
endinterface

`default_nettype wire

>>> rtl/sfcp_frame_if.sv
// ----------------------------------------------------------------------------
// sfcp_frame_if
// Output channel: one beat per payload byte with frame information.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcp_frame_if;
	logic        valid;
	logic        ready;
	logic [7:0]  frame_command;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic        byte_kept;
	logic        frame_end;
	logic [7:0]  frame_length;

	modport source (output valid, output frame_command, output payload_byte,
		output byte_index, output byte_kept, output frame_end, output frame_length,
		input ready);
	modport sink (input valid, input frame_command, input payload_byte,
		input byte_index, input byte_kept, input frame_end, input frame_length,
		output ready);
endinterface

`default_nettype wire

>>> rtl/sfcp_in_reg.sv
// ----------------------------------------------------------------------------
// sfcp_in_reg
// Input register stage: holds one accepted beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire sfcp_pkg::item_t in_item,
	output logic                in_ready,
	input  wire logic           take,
	output logic                valid_s1,
	output sfcp_pkg::item_t     item_s1
);
	import sfcp_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sfcp_core.sv
// ----------------------------------------------------------------------------
// sfcp_core
// Frame parser state: sync hunt, command, length and payload tracking.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_framed_command_parser_assert.svh"

module sfcp_core #(
	parameter int unsigned PAYLOAD_STORE = sfcp_pkg::PAYLOAD_STORE_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire sfcp_pkg::item_t item,
	output logic            res_valid,
	output sfcp_pkg::result_t res
);
	import sfcp_pkg::*;

	localparam logic [16:0] STORE_LIM = 17'(PAYLOAD_STORE);
	localparam logic [7:0]  LEN_CLIP  = (PAYLOAD_STORE > 255) ? LEN_SAT : 8'(PAYLOAD_STORE);

	phase_t                phase_q, phase_d;
	logic [SYNC_IDX_W-1:0] sync_q;
	logic [7:0]            cmd_q;
	logic [7:0]            len_lo_q;
	logic                  len_seen_q;
	logic [15:0]           ann_q;
	logic [15:0]           cnt_q;

	logic        is_resync;
	logic        sync_hit;
	logic        cmd_ok;
	logic [16:0] next_idx;
	logic        last;

	assign is_resync = (item.kind == KIND_RESYNC);
	assign sync_hit  = (item.byte_value == sync_byte(sync_q));
	assign cmd_ok    = (item.byte_value > CMD_LO) && (item.byte_value < CMD_HI);
	assign next_idx  = {1'b0, cnt_q} + 17'd1;
	assign last      = (next_idx >= {1'b0, ann_q});

	// next state
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (is_resync) begin
				phase_d = PH_HUNT;
			end else begin
				case (phase_q)
					PH_HUNT: begin
						if (sync_hit && sync_q == SYNC_LAST) phase_d = PH_WAIT_CMD;
					end
					PH_WAIT_CMD: begin
						if (cmd_ok) phase_d = PH_LENGTH;
					end
					PH_LENGTH: begin
						if (len_seen_q) phase_d = PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (last) phase_d = PH_WAIT_CMD;
					end
					default: phase_d = PH_HUNT;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res_valid         = fire && !is_resync && (phase_q == PH_PAYLOAD);
		res.frame_command = cmd_q;
		res.payload_byte  = item.byte_value;
		res.byte_index    = cnt_q;
		res.byte_kept     = ({1'b0, cnt_q} < STORE_LIM);
		res.frame_end     = last;
		res.frame_length  = 8'd0;
		if (last) begin
			res.frame_length = ({1'b0, ann_q} > {9'd0, LEN_CLIP}) ? LEN_CLIP : ann_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			sync_q     <= '0;
			cmd_q      <= '0;
			len_lo_q   <= '0;
			len_seen_q <= 1'b0;
			ann_q      <= '0;
			cnt_q      <= '0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				if (is_resync) begin
					sync_q <= '0;
				end else begin
					case (phase_q)
						PH_HUNT: begin
							// a mismatch restarts the pattern without rechecking this byte
							sync_q <= sync_hit ? sync_q + 1'b1 : '0;
							if (sync_hit && sync_q == SYNC_LAST) cmd_q <= '0;
						end
						PH_WAIT_CMD: begin
							if (cmd_ok) begin
								cmd_q      <= item.byte_value;
								len_seen_q <= 1'b0;
							end
						end
						PH_LENGTH: begin
							if (!len_seen_q) begin
								len_lo_q   <= item.byte_value;
								len_seen_q <= 1'b1;
							end else begin
								ann_q      <= {item.byte_value, len_lo_q};
								len_seen_q <= 1'b0;
								cnt_q      <= '0;
							end
						end
						PH_PAYLOAD: begin
							if (last) begin
								cmd_q <= '0;
								cnt_q <= '0;
							end else begin
								cnt_q <= next_idx[15:0];
							end
						end
						default: sync_q <= '0;
					endcase
				end
			end
		end
	end

	`SFCP_ASSERT_NXT(a_resync_to_hunt, fire && is_resync, (phase_q == PH_HUNT) && (sync_q == '0))
	`SFCP_ASSERT_NXT(a_end_to_wait, res_valid && res.frame_end, phase_q == PH_WAIT_CMD)
	`SFCP_ASSERT_IMP(a_cnt_in_frame, phase_q == PH_PAYLOAD, (cnt_q < ann_q) || (cnt_q == 16'd0))

endmodule

`default_nettype wire

>>> rtl/sfcp_out_reg.sv
// ----------------------------------------------------------------------------
// sfcp_out_reg
// Result register: holds one beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire sfcp_pkg::result_t load_data,
	output logic               can_load,
	output logic               out_valid,
	input  wire logic          out_ready,
	output sfcp_pkg::result_t  out_data
);
	import sfcp_pkg::*;

	logic valid_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			out_data <= load_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sync_framed_command_parser.sv
// ----------------------------------------------------------------------------
// sync_framed_command_parser
// Hunts for the AA FF 55 00 sync word, then parses command, length and payload.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | beats
//  link    | in  | kind, byte_value                              | one per byte/resync
//  frame   | out | frame_command, payload_byte, byte_index,      | one per payload byte
//          |     | byte_kept, frame_end, frame_length            |
//
// One beat per cycle sustained: a beat is held in the input register, is parsed
// there and any result lands in the result register, from which it is offered
// on frame. The parser advances only when the result register is free or being
// emptied, so a stalled sink backs up to link.
// Reset returns the parser to sync hunt with all counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_framed_command_parser_assert.svh"

module sync_framed_command_parser #(
	parameter int unsigned PAYLOAD_STORE = sfcp_pkg::PAYLOAD_STORE_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sfcp_link_if.sink link,
	sfcp_frame_if.source frame
);
	import sfcp_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    can_load;
	logic    res_valid;
	result_t res;
	result_t out_data;

	assign in_item.kind       = link.kind;
	assign in_item.byte_value = link.byte_value;

	assign advance = valid_s1 && can_load;

	sfcp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link.valid),
		.in_item  (in_item),
		.in_ready (link.ready),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfcp_core #(
		.PAYLOAD_STORE (PAYLOAD_STORE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sfcp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_data (res),
		.can_load  (can_load),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.out_data  (out_data)
	);

	assign frame.frame_command = out_data.frame_command;
	assign frame.payload_byte  = out_data.payload_byte;
	assign frame.byte_index    = out_data.byte_index;
	assign frame.byte_kept     = out_data.byte_kept;
	assign frame.frame_end     = out_data.frame_end;
	assign frame.frame_length  = out_data.frame_length;

	`SFCP_ASSERT_IMP(a_no_overwrite, frame.valid && !frame.ready, !(advance && res_valid))
	`SFCP_ASSERT_IMP(a_empty_stage_ready, !valid_s1, link.ready)

endmodule

`default_nettype wire
